@@ hw/rtl/dfs_postorder_reach_defines.svh @@
// Assertion macros shared by the depth-first search RTL.
// Included by the modules that check their own sequencing; no other dependencies.
`ifndef DFS_POSTORDER_REACH_DEFINES_SVH
`define DFS_POSTORDER_REACH_DEFINES_SVH
`ifndef SYNTHESIS
`define DFSPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfspr assertion failed");
`define DFSPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfspr assertion failed");
`else
`define DFSPR_ASSERT_NOW(label, ante, cons)
`define DFSPR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/dfspr_pkg.sv @@
// Shared types and constants for the depth-first search block.
// No dependencies; imported by dfspr_pick and dfs_postorder_reach.
`default_nettype none
package dfspr_pkg;
  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int DEPTH_W   = $clog2(MAX_NODES + 1);
  localparam int CNT_W     = 5;
  localparam int ROW_W     = 16;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef logic [MAX_NODES-1:0] row_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] idx;
  } pick_t;
endpackage
`default_nettype wire

@@ hw/rtl/dfs_postorder_reach.sv @@
// Depth-first search over a bit-row adjacency matrix, results in post-order.
// Depends on dfspr_pkg, dfspr_pick and dfs_postorder_reach_defines.svh.
//
// A load request (kind 0) writes one adjacency row. A search request (kind 1)
// clears the visited marks and walks from the source with a hardware frame
// stack; each finished node leaves as one result, the source last with out_last
// set. The walk runs one step a cycle, unless a stalled result holds back a pop,
// through a single picker that selects the lowest-index unvisited neighbor
// below node_count: every reachable node is pushed once and popped once.
// in_stall stays high while a search is in flight, and the next request is
// taken once the last pop has returned the block to idle. node_count is
// clamped to MAX_NODES; write it only while no search is in flight.
`default_nettype none
module dfs_postorder_reach (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [3:0]                   in_row_index,
  input  wire logic [dfspr_pkg::ROW_W-1:0]  in_row_bits,
  input  wire logic [3:0]                   in_source,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [3:0]                        out_node,
  output logic                              out_last,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [dfspr_pkg::CNT_W-1:0]  cfg_data
);
  import dfspr_pkg::*;

`include "dfs_postorder_reach_defines.svh"

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t              state_r;
  row_t                adj_r [MAX_NODES];
  logic [NODE_W-1:0]   frame_r [MAX_NODES];
  logic [DEPTH_W-1:0]  depth_r;
  logic [NODE_W-1:0]   top_r;
  row_t                visited_r;
  logic [CNT_W-1:0]    node_count_r;
  logic                out_valid_r;
  logic [3:0]          out_node_r;
  logic                out_last_r;

  logic [CNT_W-1:0]    eff_count;
  row_t                lim_mask;
  row_t                cand;
  pick_t               pick;
  logic                out_free;
  logic                in_take;
  logic                do_pop;
  logic [NODE_W-1:0]   push_idx;
  logic [NODE_W-1:0]   pop_idx;

  assign eff_count = (node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_r;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      lim_mask[i] = (CNT_W'(i) < eff_count);
    end
  end

  // edges of the top node that lead somewhere new
  assign cand = adj_r[top_r] & ~visited_r & lim_mask;

  dfspr_pick u_pick (
    .cand (cand),
    .pick (pick)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_take  = in_valid && !in_stall;
  assign do_pop   = (state_r == ST_SCAN) && !pick.found && out_free;
  assign push_idx = depth_r[NODE_W-1:0];
  assign pop_idx  = NODE_W'(depth_r - DEPTH_W'(2));

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_node  = out_node_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      depth_r      <= '0;
      visited_r    <= '0;
      node_count_r <= CNT_W'(MAX_NODES);
      out_valid_r  <= 1'b0;
    end else begin
      // a pop in the same cycle refills the result register instead
      if (out_valid_r && !out_stall && !do_pop) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            if (in_kind == KIND_LOAD) begin
              adj_r[in_row_index] <= in_row_bits[MAX_NODES-1:0];
            end else begin
              visited_r  <= row_t'(1) << in_source;
              frame_r[0] <= in_source;
              top_r      <= in_source;
              depth_r    <= DEPTH_W'(1);
              state_r    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (pick.found) begin
            visited_r[pick.idx] <= 1'b1;
            frame_r[push_idx]   <= pick.idx;
            top_r               <= pick.idx;
            depth_r             <= depth_r + DEPTH_W'(1);
          end else if (do_pop) begin
            out_valid_r <= 1'b1;
            out_node_r  <= top_r;
            out_last_r  <= (depth_r == DEPTH_W'(1));
            depth_r     <= depth_r - DEPTH_W'(1);
            top_r       <= frame_r[pop_idx];
            if (depth_r == DEPTH_W'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `DFSPR_ASSERT_NOW(a_depth_range, state_r == ST_SCAN, (depth_r != '0) && (depth_r <= DEPTH_W'(MAX_NODES)))
  `DFSPR_ASSERT_NOW(a_top_visited, state_r == ST_SCAN, visited_r[top_r])
  `DFSPR_ASSERT_NOW(a_stack_bound, state_r == ST_SCAN, $countones(visited_r) >= int'(depth_r))
  `DFSPR_ASSERT_NEXT(a_last_ends, do_pop && (depth_r == DEPTH_W'(1)), (state_r == ST_IDLE) && out_valid_r && out_last_r)
endmodule
`default_nettype wire

@@ hw/rtl/dfspr_pick.sv @@
// Lowest-index picker: finds the first unvisited neighbor of the current node.
// Depends on dfspr_pkg.
`default_nettype none
module dfspr_pick (
  input  dfspr_pkg::row_t  cand,
  output dfspr_pkg::pick_t pick
);
  import dfspr_pkg::*;

  always_comb begin
    pick.found = |cand;
    pick.idx   = '0;
    // scan from the top so the lowest set bit wins
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick.idx = NODE_W'(i);
      end
    end
  end
endmodule
`default_nettype wire
